// ===== hdl/first_fit_block_table_core_assert.svh =====
// Assertion macros for the first-fit block table core.
// Used by the top level; relies on clk and rst_n being visible where expanded.
`ifndef FIRST_FIT_BLOCK_TABLE_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define FFBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FFBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FFBT_ASSERT_NOW(lbl, ante, cons, msg)
`define FFBT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/ffbt_pkg.sv =====
// Shared types and constants for the first-fit block table core.
// No dependencies; imported by ffbt_in_if, ffbt_out_if, ffbt_seq and the top level.
`default_nettype none

package ffbt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 2'd0,
    OP_FIND    = 2'd1,
    OP_MARK    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic              busy;
    logic [DATA_W-1:0] orig_size;
    logic [DATA_W-1:0] capacity;
    logic [DATA_W-1:0] addr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
  } ram_rd_t;

  typedef struct packed {
    logic [DATA_W-1:0] found_address;
    logic [DATA_W-1:0] released_size;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic              idle;
    logic [CNT_W-1:0]  count;
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ffbt_in_if.sv =====
// Input channel of the first-fit block table: valid/ready plus request fields.
// Depends on ffbt_pkg for field widths.
`default_nettype none

interface ffbt_in_if;
  import ffbt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] block_address;
  logic [DATA_W-1:0] request_size;

  modport source (output valid, output operation, output block_address,
                  output request_size, input ready);
  modport sink   (input valid, input operation, input block_address,
                  input request_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/ffbt_out_if.sv =====
// Result channel of the first-fit block table: valid/ready plus result fields.
// Depends on ffbt_pkg for field widths.
`default_nettype none

interface ffbt_out_if;
  import ffbt_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] found_address;
  logic [DATA_W-1:0] released_size;
  logic [ST_W-1:0]   status;

  modport source (output valid, output found_address, output released_size,
                  output status, input ready);
  modport sink   (input valid, input found_address, input released_size,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/ffbt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
`default_nettype none

module ffbt_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ffbt_seq.sv =====
// Operation sequencer: appends entries and scans the table RAM with a
// one-entry-per-cycle read/check pipeline. Depends on ffbt_pkg.
`default_nettype none

module ffbt_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [ffbt_pkg::OP_W-1:0]   in_operation,
  input  wire logic [ffbt_pkg::DATA_W-1:0] in_block_address,
  input  wire logic [ffbt_pkg::DATA_W-1:0] in_request_size,
  output      logic                      res_valid,
  input  wire logic                      res_taken,
  output      ffbt_pkg::res_t            res,
  output      ffbt_pkg::ram_wr_t         ram_wr,
  output      ffbt_pkg::ram_rd_t         ram_rd,
  input  wire ffbt_pkg::entry_t          ram_rdata,
  output      ffbt_pkg::seq_stat_t       stat
);
  import ffbt_pkg::*;

  seq_state_t        state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] req_r, req_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [DATA_W-1:0] found_r, found_nxt;
  logic [DATA_W-1:0] rel_r, rel_nxt;
  status_t           stat_r, stat_nxt;
  logic              issue;
  logic              hit;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  // Item fields, scan position and result
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    req_r     <= req_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    found_r   <= found_nxt;
    rel_r     <= rel_nxt;
    stat_r    <= stat_nxt;
  end

  // Next state: read entry rd_idx while checking the entry read last cycle
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    chk_idx_nxt = chk_idx_r;
    chk_vld_nxt = 1'b0;
    found_nxt   = found_r;
    rel_nxt     = rel_r;
    stat_nxt    = stat_r;
    ram_wr      = '0;
    ram_rd      = '0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    issue       = 1'b0;
    hit         = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = op_t'(in_operation);
          addr_nxt   = in_block_address;
          req_nxt    = in_request_size;
          found_nxt  = '0;
          rel_nxt    = '0;
          stat_nxt   = ST_NOMATCH;
          rd_idx_nxt = '0;
          if (op_t'(in_operation) == OP_APPEND) begin
            if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
              stat_nxt = ST_FULL;
            end else begin
              ram_wr.en             = 1'b1;
              ram_wr.idx            = cnt_r[IDX_W-1:0];
              ram_wr.data.busy      = 1'b1;
              ram_wr.data.orig_size = in_request_size;
              ram_wr.data.capacity  = in_request_size;
              ram_wr.data.addr      = in_block_address;
              cnt_nxt               = cnt_r + 1'b1;
              stat_nxt              = ST_OK;
            end
            state_nxt = S_FINISH;
          end else if (cnt_r == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read side
        issue = (rd_idx_r < cnt_r);
        if (issue) begin
          ram_rd.en   = 1'b1;
          ram_rd.idx  = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          chk_vld_nxt = 1'b1;
        end
        // Check side
        if (chk_vld_r) begin
          case (op_r)
            OP_FIND: begin
              if (!ram_rdata.busy && (ram_rdata.capacity >= req_r)) begin
                hit       = 1'b1;
                found_nxt = ram_rdata.addr;
                stat_nxt  = ST_OK;
              end
            end
            OP_MARK: begin
              if (ram_rdata.addr == addr_r) begin
                ram_wr.en            = 1'b1;
                ram_wr.idx           = chk_idx_r;
                ram_wr.data          = ram_rdata;
                ram_wr.data.busy     = 1'b1;
                ram_wr.data.capacity = req_r;
                stat_nxt             = ST_OK;
              end
            end
            OP_RELEASE: begin
              if (ram_rdata.addr == addr_r) begin
                hit              = 1'b1;
                ram_wr.en        = 1'b1;
                ram_wr.idx       = chk_idx_r;
                ram_wr.data      = ram_rdata;
                ram_wr.data.busy = 1'b0;
                rel_nxt          = ram_rdata.orig_size;
                stat_nxt         = ST_OK;
              end
            end
            default: ;
          endcase
          // Stop on first hit, or after the last entry is checked
          if (hit || !issue) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        res_valid = 1'b1;
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res.found_address = found_r;
  assign res.released_size = rel_r;
  assign res.status        = stat_r;
  assign stat.idle         = (state_r == S_IDLE);
  assign stat.count        = cnt_r;

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_table_core.sv =====
// First-fit block table core: top level with sequencer, table RAM and output register.
// Depends on ffbt_pkg, ffbt_in_if, ffbt_out_if, ffbt_ram, ffbt_seq and the assert header.
`default_nettype none

// Keeps up to 64 blocks (address, capacity, original size, busy) in insertion
// order in a single RAM with a registered read port, and handles one item at a
// time. Append writes its entry when the item is accepted. Find, mark-used and
// release read the table one entry per cycle, checking each entry the cycle
// after it is read, and skip the scan on an empty table; find and release stop
// at the first hit. A finished result sits in an output register, so the next
// item is accepted while the result waits to be taken. The table needs no
// clearing after reset: only the entry count is reset and scans never pass it.
module first_fit_block_table_core (
  input wire logic    clk,
  input wire logic    rst_n,
  ffbt_in_if.sink     in_if,
  ffbt_out_if.source  out_if
);
  import ffbt_pkg::*;

  ram_wr_t           ram_wr;
  ram_rd_t           ram_rd;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  res_t              res;
  logic              res_valid;
  logic              res_taken;
  seq_stat_t         seq_stat;
  logic              out_valid_r;
  res_t              out_res_r;
  logic [CNT_W-1:0]  cnt;
  logic              at_max;
  logic              over_max;
  logic              full_res;
  logic              append_acc;

  assign res_taken = !out_valid_r || out_if.ready;

  ffbt_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_operation     (in_if.operation),
    .in_block_address (in_if.block_address),
    .in_request_size  (in_if.request_size),
    .res_valid        (res_valid),
    .res_taken        (res_taken),
    .res              (res),
    .ram_wr           (ram_wr),
    .ram_rd           (ram_rd),
    .ram_rdata        (ram_rdata),
    .stat             (seq_stat)
  );

  ffbt_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.idx),
    .wdata (ram_wr.data),
    .re    (ram_rd.en),
    .raddr (ram_rd.idx),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_taken) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_taken) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.found_address = out_res_r.found_address;
  assign out_if.released_size = out_res_r.released_size;
  assign out_if.status        = out_res_r.status;

  // Terms for the checks
  assign cnt        = seq_stat.count;
  assign at_max     = (cnt == CNT_W'(MAX_ENTRIES));
  assign over_max   = (cnt > CNT_W'(MAX_ENTRIES));
  assign full_res   = res_valid && (res.status == ST_FULL);
  assign append_acc = in_if.valid && in_if.ready && (in_if.operation == OP_APPEND) && !at_max;

  // Checks
  `include "first_fit_block_table_core_assert.svh"

  `FFBT_ASSERT_NOW(a_count_range, 1'b1, !over_max, "entry count over table size")
  `FFBT_ASSERT_NOW(a_full_only_at_max, full_res, at_max, "full status with room left")
  `FFBT_ASSERT_NOW(a_no_accept_busy, !seq_stat.idle, !in_if.ready, "input ready while busy")
  `FFBT_ASSERT_NEXT(a_append_counts, append_acc, cnt == $past(cnt) + 1'b1, "table did not grow")

endmodule

`default_nettype wire
